>>> rtl/bfr_pkg.sv
// Package for the binary frame receiver: result codes, frame positions,
// sync bytes and the result record shared by the parser and output stage.
// No dependencies.
package bfr_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_GOOD      = 2'd1;
  localparam logic [1:0] KIND_CHECK_ERR = 2'd2;
  localparam logic [1:0] KIND_LEN_ERR   = 2'd3;

  // Sync pair
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Frame byte positions (sync bytes are positions 0 and 1)
  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] POS_CLASS    = 17'd2;
  localparam logic [CNT_W-1:0] POS_ID       = 17'd3;
  localparam logic [CNT_W-1:0] POS_LEN_LO   = 17'd4;
  localparam logic [CNT_W-1:0] POS_LEN_HI   = 17'd5;
  localparam logic [CNT_W-1:0] HEADER_END   = 17'd6;
  localparam logic [CNT_W-1:0] FRAME_OVHD   = 17'd8;
  localparam logic [CNT_W-1:0] CHECK_BYTES  = 17'd2;

  localparam logic [CNT_W-1:0] MAX_LEN_RESET = 17'd4096;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_len;
  } bfr_result_t;

endpackage

>>> rtl/binary_frame_receiver_fletcher.sv
// Binary frame receiver (sync 0xB5 0x62, Fletcher-8 checksum), top level.
// Holds the input register and the length limit register.
// Depends on bfr_pkg, bfr_parser, bfr_out_reg.
//
// Usage:
//   Input channel: one received byte per request on rx_byte, handshake
//   in_valid / in_stall. Output channel: one result per request on kind,
//   payload_byte, msg_class, msg_id, payload_len, handshake out_valid /
//   out_stall. A request moves at an edge with valid high and stall low.
//   Results: one per payload byte, one at frame end (good or checksum
//   error), one for a length error; sync, header and the first checksum
//   byte give none.
//   Path: a byte goes through the input register and the parser step into
//   the result register. Throughput: one byte per cycle while out_stall is
//   low, set by the single parser step between the two registers.
//   cfg_wr_en / cfg_wr_data write max_frame_len (total frame length limit).
//   Reset (rst, synchronous): parser returns to hunting, both registers
//   empty, max_frame_len = 4096.
//   When out_stall holds a result, the next byte still enters the input
//   register; in_stall rises once that register is full too.
module binary_frame_receiver_fletcher import bfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic [7:0]        payload_byte,
  output logic [7:0]        msg_class,
  output logic [7:0]        msg_id,
  output logic [15:0]       payload_len
);

  logic             in_full;
  logic [7:0]       in_byte;
  logic [CNT_W-1:0] max_frame_len;
  logic             free;
  logic             step;
  logic             res_valid;
  bfr_result_t      res;
  bfr_result_t      out_data;

  // Byte in the input register moves through the parser when the
  // result register can take it
  assign step     = in_full && free;
  assign in_stall = in_full && !free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  // Length limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_frame_len <= cfg_wr_data;
    end
  end

  bfr_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (in_byte),
    .max_frame_len (max_frame_len),
    .res_valid     (res_valid),
    .res           (res)
  );

  bfr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_data (res),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign kind         = out_data.kind;
  assign payload_byte = out_data.payload_byte;
  assign msg_class    = out_data.msg_class;
  assign msg_id       = out_data.msg_id;
  assign payload_len  = out_data.payload_len;

endmodule

>>> rtl/bfr_parser.sv
// Frame parser: sync hunt, header capture, length check, Fletcher-8 sum
// and checksum compare, one byte per step. Depends on bfr_pkg.
module bfr_parser import bfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic [CNT_W-1:0] max_frame_len,
  output logic             res_valid,
  output bfr_result_t      res
);

  logic [7:0]       prev_hunt_byte, prev_hunt_byte_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [CNT_W-1:0] frame_len, frame_len_next;
  logic [7:0]       sum_a, sum_a_next;
  logic [7:0]       sum_b, sum_b_next;
  logic [7:0]       class_reg, class_reg_next;
  logic [7:0]       id_reg, id_reg_next;
  logic [7:0]       got_check_a, got_check_a_next;

  logic [7:0]       add_a;
  logic [7:0]       add_b;
  logic [15:0]      hdr_len;
  logic [CNT_W-1:0] hdr_frame_len;
  logic [CNT_W-1:0] check_pos;
  logic [15:0]      cur_plen;

  // Running Fletcher-8 sums with the current byte folded in
  assign add_a         = sum_a + data_byte;
  assign add_b         = sum_b + add_a;
  assign hdr_len       = {data_byte, frame_len[7:0]};
  assign hdr_frame_len = {1'b0, hdr_len} + FRAME_OVHD;
  assign check_pos     = frame_len - CHECK_BYTES;
  assign cur_plen      = 16'(frame_len - FRAME_OVHD);

  // Next state and result
  always_comb begin
    prev_hunt_byte_next = prev_hunt_byte;
    byte_count_next     = byte_count;
    frame_len_next      = frame_len;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    class_reg_next      = class_reg;
    id_reg_next         = id_reg;
    got_check_a_next    = got_check_a;
    res_valid           = 1'b0;
    res.kind            = KIND_PAYLOAD;
    res.payload_byte    = 8'd0;
    res.msg_class       = class_reg;
    res.msg_id          = id_reg;
    res.payload_len     = cur_plen;

    if (byte_count == '0) begin
      // hunting for the sync pair
      prev_hunt_byte_next = data_byte;
      if (prev_hunt_byte == SYNC_FIRST && data_byte == SYNC_SECOND) begin
        byte_count_next = POS_CLASS;
        sum_a_next      = 8'd0;
        sum_b_next      = 8'd0;
      end
    end else if (byte_count < HEADER_END) begin
      byte_count_next = byte_count + 1'b1;
      sum_a_next      = add_a;
      sum_b_next      = add_b;
      priority if (byte_count == POS_CLASS) begin
        class_reg_next = data_byte;
      end else if (byte_count == POS_ID) begin
        id_reg_next = data_byte;
      end else if (byte_count == POS_LEN_LO) begin
        frame_len_next = {9'd0, data_byte};
      end else begin
        // second length byte: total length check
        frame_len_next = hdr_frame_len;
        if (hdr_frame_len > max_frame_len) begin
          byte_count_next = '0;
          res_valid       = 1'b1;
          res.kind        = KIND_LEN_ERR;
          res.payload_len = hdr_len;
        end
      end
    end else begin
      byte_count_next = byte_count + 1'b1;
      priority if (byte_count < check_pos) begin
        // payload byte
        sum_a_next       = add_a;
        sum_b_next       = add_b;
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = data_byte;
      end else if (byte_count == check_pos) begin
        got_check_a_next = data_byte;
      end else begin
        // second checksum byte ends the frame
        byte_count_next = '0;
        res_valid       = 1'b1;
        res.kind        = (got_check_a == sum_a && data_byte == sum_b) ?
                          KIND_GOOD : KIND_CHECK_ERR;
      end
    end

    if (!step) begin
      res_valid = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_hunt_byte <= 8'd0;
      byte_count     <= '0;
      frame_len      <= '0;
      sum_a          <= 8'd0;
      sum_b          <= 8'd0;
      class_reg      <= 8'd0;
      id_reg         <= 8'd0;
      got_check_a    <= 8'd0;
    end else if (step) begin
      prev_hunt_byte <= prev_hunt_byte_next;
      byte_count     <= byte_count_next;
      frame_len      <= frame_len_next;
      sum_a          <= sum_a_next;
      sum_b          <= sum_b_next;
      class_reg      <= class_reg_next;
      id_reg         <= id_reg_next;
      got_check_a    <= got_check_a_next;
    end
  end

endmodule

>>> rtl/bfr_out_reg.sv
// Result register on the output channel: holds one result until taken
// and reports when it can take the next one. Depends on bfr_pkg.
module bfr_out_reg import bfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  bfr_result_t load_data,
  output logic        free,
  output logic        out_valid,
  input  logic        out_stall,
  output bfr_result_t out_data
);

  // Free when empty or when the held request leaves this cycle
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

>>> tb/sv/bfr_frame_checker.sv
// Checker for binary_frame_receiver_fletcher: watches both request channels and the
// limit register port, predicts each result from the accepted bytes and compares.
// Depends on bfr_pkg.
module bfr_frame_checker import bfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       rx_byte,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       kind,
  input  logic [7:0]       payload_byte,
  input  logic [7:0]       msg_class,
  input  logic [7:0]       msg_id,
  input  logic [15:0]      payload_len,
  output int               mismatches,
  output int               pending
);

  // Results still owed by the block, oldest first
  bfr_result_t results_due [$];

  // Shadow of the parser
  logic [CNT_W-1:0] len_limit;
  logic [CNT_W-1:0] frame_pos;    // 0 while hunting
  logic [CNT_W-1:0] frame_total;  // payload + overhead; low length byte during header
  logic [7:0]       hunt_prev;
  logic [7:0]       fl_a;
  logic [7:0]       fl_b;
  logic [7:0]       cur_class;
  logic [7:0]       cur_id;
  logic [7:0]       rx_check_a;

  task automatic queue_result(input logic [1:0] k, input logic [7:0] pb,
                              input logic [15:0] plen);
    bfr_result_t r;
    r.kind         = k;
    r.payload_byte = pb;
    r.msg_class    = cur_class;
    r.msg_id       = cur_id;
    r.payload_len  = plen;
    results_due.push_back(r);
  endtask

  task automatic flag_field(input string name, input logic [15:0] want,
                            input logic [15:0] got);
    mismatches++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
  endtask

  // Advance the shadow parser by one received byte
  task automatic parse_byte(input logic [7:0] b);
    logic [CNT_W-1:0] at;
    logic [CNT_W-1:0] body_len;
    logic [15:0]      hdr_len;
    if (frame_pos == '0) begin
      // hunting: sync pair must come back to back
      if (hunt_prev == SYNC_FIRST && b == SYNC_SECOND) begin
        frame_pos = POS_CLASS;
        fl_a = '0;
        fl_b = '0;
      end
      hunt_prev = b;
    end else begin
      at = frame_pos;
      frame_pos = at + 1'b1;
      if (at < HEADER_END) begin
        fl_a = fl_a + b;
        fl_b = fl_b + fl_a;
        unique case (at)
          POS_CLASS: cur_class = b;
          POS_ID: cur_id = b;
          POS_LEN_LO: frame_total = {9'd0, b};
          default: begin
            // length check happens once, on the high length byte
            hdr_len = {b, frame_total[7:0]};
            frame_total = {1'b0, hdr_len} + FRAME_OVHD;
            if (frame_total > len_limit) begin
              frame_pos = '0;
              queue_result(KIND_LEN_ERR, 8'd0, hdr_len);
            end
          end
        endcase
      end else begin
        body_len = frame_total - FRAME_OVHD;
        if (at < frame_total - CHECK_BYTES) begin
          fl_a = fl_a + b;
          fl_b = fl_b + fl_a;
          queue_result(KIND_PAYLOAD, b, body_len[15:0]);
        end else if (at == frame_total - CHECK_BYTES) begin
          rx_check_a = b;
        end else begin
          frame_pos = '0;
          if (rx_check_a == fl_a && b == fl_b) begin
            queue_result(KIND_GOOD, 8'd0, body_len[15:0]);
          end else begin
            queue_result(KIND_CHECK_ERR, 8'd0, body_len[15:0]);
          end
        end
      end
    end
  endtask

  // Results are checked before the byte of the same edge is parsed; a result
  // always trails its byte, with the input and result registers between them.
  always @(posedge clk) begin : watch
    bfr_result_t want;
    if (rst) begin
      results_due.delete();
      len_limit   = MAX_LEN_RESET;
      frame_pos   = '0;
      frame_total = '0;
      hunt_prev   = '0;
      fl_a        = '0;
      fl_b        = '0;
      cur_class   = '0;
      cur_id      = '0;
      rx_check_a  = '0;
      mismatches  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result mismatch: expected none, actual kind %0d len %h", $time,
                   kind, payload_len);
        end else begin
          want = results_due.pop_front();
          if (kind !== want.kind) flag_field("kind", 16'(want.kind), 16'(kind));
          if (payload_byte !== want.payload_byte)
            flag_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
          if (msg_class !== want.msg_class)
            flag_field("msg_class", 16'(want.msg_class), 16'(msg_class));
          if (msg_id !== want.msg_id) flag_field("msg_id", 16'(want.msg_id), 16'(msg_id));
          if (payload_len !== want.payload_len)
            flag_field("payload_len", want.payload_len, payload_len);
        end
      end
      if (cfg_wr_en) len_limit = cfg_wr_data;
      if (in_valid && !in_stall) parse_byte(rx_byte);
    end
    pending = results_due.size();
  end

endmodule

>>> tb/sv/binary_frame_receiver_fletcher_tb.sv
// Testbench top for binary_frame_receiver_fletcher: clock, reset, frame and noise
// stimulus, output stalls, limit register writes and the verdict.
// Depends on bfr_pkg, binary_frame_receiver_fletcher and bfr_frame_checker.
module binary_frame_receiver_fletcher_tb;
  import bfr_pkg::*;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int ITEM_TARGET     = 1650;
  localparam int QUIET_FROM      = 1450;
  localparam int NUM_PHASES      = 7;
  localparam int MAX_FRAME_TOTAL = 65543;
  localparam int OVHD            = FRAME_OVHD;
  localparam int LONG_HOLD       = 200;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       rx_byte = 8'd0;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       kind;
  logic [7:0]       payload_byte;
  logic [7:0]       msg_class;
  logic [7:0]       msg_id;
  logic [15:0]      payload_len;

  int   mismatches;
  int   pending;
  int   cycles = 0;
  int   frame_bytes = 0;   // bytes sent as part of frames
  int   cur_limit = 4096;  // limit the block holds, for shaping frames
  bit   counting = 1'b0;
  bit   quiet = 1'b0;      // no idling in the last part of the run
  bit   bursty = 1'b0;
  bit   long_hold_req = 1'b0;
  int   stall_left = 0;
  int   mode_left = 0;

  always #5 clk = ~clk;

  binary_frame_receiver_fletcher u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .msg_class    (msg_class),
    .msg_id       (msg_id),
    .payload_len  (payload_len)
  );

  bfr_frame_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .msg_class    (msg_class),
    .msg_id       (msg_id),
    .payload_len  (payload_len),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Output side: stretches with and without stall bursts, plus one long hold
  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(50, 400);
      bursty = ($urandom_range(0, 2) != 0);
    end else begin
      mode_left--;
    end
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (bursty && !quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One byte request, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && bursty && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    if (counting) frame_bytes++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sync, header, sent_len payload bytes; the checksum only if the payload is complete
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id, input int hdr_len,
                            input int sent_len, input logic [15:0] ck_flip);
    logic [7:0] hdr [4];
    logic [7:0] sa;
    logic [7:0] sb;
    logic [7:0] pb;
    int         i;
    sa = '0;
    sb = '0;
    hdr[0] = cls;
    hdr[1] = id;
    hdr[2] = hdr_len[7:0];
    hdr[3] = hdr_len[15:8];
    counting = 1'b1;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    for (i = 0; i < 4; i++) begin
      sa += hdr[i];
      sb += sa;
      send_byte(hdr[i]);
    end
    // over the limit the block is back to hunting after the header
    if (hdr_len + OVHD <= cur_limit) begin
      for (i = 0; i < sent_len; i++) begin
        pb = ($urandom_range(0, 15) == 0) ? SYNC_FIRST : 8'($urandom_range(0, 255));
        sa += pb;
        sb += sa;
        send_byte(pb);
      end
      if (sent_len == hdr_len) begin
        send_byte(sa ^ ck_flip[7:0]);
        send_byte(sb ^ ck_flip[15:8]);
      end
    end
    counting = 1'b0;
  endtask

  // Payload length that fits the current limit; mostly short
  function automatic int pick_len();
    int room;
    int n;
    room = cur_limit - OVHD;
    if (room < 0) room = 0;
    if ($urandom_range(0, 7) == 0) n = room;
    else if ($urandom_range(0, 29) == 0) n = $urandom_range(25, 300);
    else n = $urandom_range(0, 24);
    if (n > room) n = room;
    if (n > 300) n = 300;
    return n;
  endfunction

  // Let the block empty out before a register write or the verdict
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int         ph;
    int         r;
    int         n;
    int         lo;
    logic [7:0] last_noise;
    int         phase_limit [NUM_PHASES];
    phase_limit = '{4096, MAX_FRAME_TOTAL, 8, 30, 0, 0, 2000};
    last_noise = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // doubled first sync byte, then an empty frame with extreme header bytes
    send_byte(SYNC_FIRST);
    send_frame(8'hFF, 8'h00, 0, 0, 16'h0000);
    // checksum error on a short payload
    send_frame(8'h00, 8'hFF, 2, 2, 16'h8001);
    // largest header length, far over the reset limit
    send_frame(8'h5A, 8'hA5, 65535, 0, 16'h0000);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        cur_limit = (ph == 4) ? $urandom_range(9, MAX_FRAME_TOTAL - 1) : phase_limit[ph];
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cur_limit[CNT_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
      end
      // long output hold while a long frame keeps coming in
      if (ph == 1) begin
        long_hold_req = 1'b1;
        send_frame(8'h0A, 8'h01, 60, 60, 16'h0000);
      end
      while (frame_bytes < (ph + 1) * ITEM_TARGET / NUM_PHASES) begin
        if (frame_bytes >= QUIET_FROM) quiet = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 60) begin
          n = pick_len();
          send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), n, n, 16'h0000);
        end else if (r < 72) begin
          // one checksum bit flipped
          n = pick_len();
          send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), n, n,
                     16'(1 << $urandom_range(0, 15)));
        end else if (r < 80 && cur_limit < MAX_FRAME_TOTAL) begin
          // header length just over the limit or anywhere above
          lo = cur_limit - OVHD + 1;
          if (lo < 0) lo = 0;
          if ($urandom_range(0, 1) == 0) n = lo;
          else n = $urandom_range(lo, 65535);
          send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), n, 0, 16'h0000);
        end else if (r < 88) begin
          // frame cut short: the next bytes are taken as its tail
          n = $urandom_range(1, 24);
          send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), n,
                     $urandom_range(0, n - 1), 16'h0000);
        end else begin
          // line noise, rich in sync bytes but never a full sync pair
          repeat ($urandom_range(1, 6)) begin
            r = $urandom_range(0, 3);
            if (r == 0) n = SYNC_FIRST;
            else if (r == 1 && last_noise != SYNC_FIRST) n = SYNC_SECOND;
            else n = $urandom_range(0, 255);
            if (last_noise == SYNC_FIRST && n == SYNC_SECOND) n = 0;
            last_noise = n[7:0];
            send_byte(n[7:0]);
          end
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
